>>> src/putm_pkg.sv
`default_nettype none
package putm_pkg;
    localparam int THREADS     = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int THREAD_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_POST   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    localparam logic [2:0] ST_POSTED     = 3'd0;
    localparam logic [2:0] ST_UNEXPECTED = 3'd1;
    localparam logic [2:0] ST_MATCHED    = 3'd2;
    localparam logic [2:0] ST_TOO_LONG   = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [1:0]  thread;
        logic [15:0] sender;
        logic [7:0]  datatype;
        logic [15:0] tag;
        logic [15:0] handle;
        logic [15:0] length;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] match_handle;
        logic [15:0] match_length;
    } t_out_word;

    typedef struct packed {
        logic [39:0] key;
        logic [15:0] handle;
        logic [15:0] length;
    } t_entry;

    typedef t_entry [QUEUE_DEPTH-1:0] t_row;
endpackage
`default_nettype wire

>>> src/posted_unexpected_tag_matcher_core.sv
// Channel   | Ports              | Handshake
// ----------+--------------------+-------------------------------------------
// request   | start, i_word      | taken when start is high and busy is low
// result    | o_done, o_result   | one-cycle strobe, cannot be held off
//
// For each word, the thread's posted and unexpected rows are read from their
// memories at acceptance, then compared, compacted or appended and written back
// in the work state (S_EXEC); the result strobes in the cycle after.
// A new word may be started in the cycle the result strobes.
// Synchronous active-low reset clears the per-thread counts and control state;
// memory contents are only ever read below the counts.
`default_nettype none
module posted_unexpected_tag_matcher_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire putm_pkg::t_in_word  i_word,
    output logic                     busy,
    output logic                     o_done,
    output putm_pkg::t_out_word      o_result
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    putm_pkg::t_row r_posted_mem     [putm_pkg::THREADS];
    putm_pkg::t_row r_unexpected_mem [putm_pkg::THREADS];

    logic [putm_pkg::CNT_W-1:0] r_pcount [putm_pkg::THREADS];
    logic [putm_pkg::CNT_W-1:0] r_ucount [putm_pkg::THREADS];

    logic                   r_state;
    putm_pkg::t_in_word     r_word;
    putm_pkg::t_row         r_prow, r_urow;
    logic                   r_done;
    putm_pkg::t_out_word    r_result;

    logic                           accept;
    logic [putm_pkg::THREAD_W-1:0]  in_thr, thr;
    putm_pkg::t_row                 srow, arow, n_srow, n_arow;
    logic [putm_pkg::CNT_W-1:0]     scount, acount;
    logic [39:0]                    key;
    logic                           seen;
    logic                           hit_i;
    putm_pkg::t_entry               hit_entry, new_entry;
    logic                           s_we, a_we;
    putm_pkg::t_out_word            n_result;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_EXEC);
    assign o_done = r_done;
    assign o_result = r_result;

    assign in_thr = putm_pkg::THREAD_W'(i_word.thread % putm_pkg::THREADS);
    assign thr    = putm_pkg::THREAD_W'(r_word.thread % putm_pkg::THREADS);
    assign key    = {r_word.sender, r_word.datatype, r_word.tag};

    always_comb begin
        srow   = (r_word.operation == putm_pkg::OP_ARRIVE) ? r_prow : r_urow;
        arow   = (r_word.operation == putm_pkg::OP_ARRIVE) ? r_urow : r_prow;
        scount = (r_word.operation == putm_pkg::OP_ARRIVE) ? r_pcount[thr] : r_ucount[thr];
        acount = (r_word.operation == putm_pkg::OP_ARRIVE) ? r_ucount[thr] : r_pcount[thr];
        new_entry = '{key: key, handle: r_word.handle, length: r_word.length};

        // Oldest match wins; entries from it onward move down one place.
        seen      = 1'b0;
        hit_entry = '0;
        n_srow    = srow;
        for (int i = 0; i < putm_pkg::QUEUE_DEPTH; i++) begin
            hit_i = (putm_pkg::CNT_W'(i) < scount) && (srow[i].key == key);
            if (hit_i && !seen) begin
                hit_entry = srow[i];
            end
            seen = seen | hit_i;
            if (seen && (i + 1 < putm_pkg::QUEUE_DEPTH)) begin
                n_srow[i] = srow[(i + 1) % putm_pkg::QUEUE_DEPTH];
            end
        end

        n_arow = arow;
        n_arow[acount[putm_pkg::IDX_W-1:0]] = new_entry;

        n_result = '0;
        s_we     = 1'b0;
        a_we     = 1'b0;
        if (seen) begin
            s_we = 1'b1;
            n_result.match_handle = hit_entry.handle;
            if (r_word.operation == putm_pkg::OP_ARRIVE) begin
                if (r_word.length > hit_entry.length) begin
                    n_result.status       = putm_pkg::ST_TOO_LONG;
                    n_result.match_length = hit_entry.length;
                end else begin
                    n_result.status       = putm_pkg::ST_MATCHED;
                    n_result.match_length = r_word.length;
                end
            end else begin
                if (hit_entry.length > r_word.length) begin
                    n_result.status       = putm_pkg::ST_TOO_LONG;
                    n_result.match_length = r_word.length;
                end else begin
                    n_result.status       = putm_pkg::ST_MATCHED;
                    n_result.match_length = hit_entry.length;
                end
            end
        end else if (acount < putm_pkg::CNT_W'(putm_pkg::QUEUE_DEPTH)) begin
            a_we = 1'b1;
            n_result.status = (r_word.operation == putm_pkg::OP_ARRIVE) ?
                              putm_pkg::ST_UNEXPECTED : putm_pkg::ST_POSTED;
        end else begin
            n_result.status = putm_pkg::ST_FULL;
        end
    end

    // Row memories: read at acceptance, write back at the end of the work cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
            r_prow <= r_posted_mem[in_thr];
            r_urow <= r_unexpected_mem[in_thr];
        end
        if (r_state == S_EXEC) begin
            r_result <= n_result;
            if (r_word.operation == putm_pkg::OP_ARRIVE) begin
                if (s_we) r_posted_mem[thr]     <= n_srow;
                if (a_we) r_unexpected_mem[thr] <= n_arow;
            end else begin
                if (s_we) r_unexpected_mem[thr] <= n_srow;
                if (a_we) r_posted_mem[thr]     <= n_arow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            for (int t = 0; t < putm_pkg::THREADS; t++) begin
                r_pcount[t] <= '0;
                r_ucount[t] <= '0;
            end
        end else begin
            r_done <= (r_state == S_EXEC);
            unique case (r_state)
                S_IDLE: begin
                    if (start) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    if (r_word.operation == putm_pkg::OP_ARRIVE) begin
                        if (s_we) r_pcount[thr] <= r_pcount[thr] - putm_pkg::CNT_W'(1);
                        if (a_we) r_ucount[thr] <= r_ucount[thr] + putm_pkg::CNT_W'(1);
                    end else begin
                        if (s_we) r_ucount[thr] <= r_ucount[thr] - putm_pkg::CNT_W'(1);
                        if (a_we) r_pcount[thr] <= r_pcount[thr] + putm_pkg::CNT_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted word did not enter the work cycle");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("work cycle did not produce exactly one result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status <= putm_pkg::ST_FULL))
        else $error("result status out of range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount[0] <= putm_pkg::CNT_W'(putm_pkg::QUEUE_DEPTH)) &&
        (r_ucount[0] <= putm_pkg::CNT_W'(putm_pkg::QUEUE_DEPTH)))
        else $error("queue count exceeds depth");
endmodule
`default_nettype wire

>>> verif/posted_unexpected_tag_matcher_core_test.sv
`timescale 1ns / 1ps
module posted_unexpected_tag_matcher_core_test;
    import putm_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  i_word;
    logic      busy;
    logic      o_done;
    t_out_word o_result;

    posted_unexpected_tag_matcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_word  (i_word),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    localparam int WATCHDOG_CYCLES = 2000;

    // Matcher state kept by the testbench
    t_entry    posted_q     [THREADS][$];
    t_entry    unexpected_q [THREADS][$];
    t_out_word expected_words[$];

    int  mismatch_count;
    int  words_sent;
    int  words_checked;
    int  idle_cycles;
    bit  gaps_on;
    int  hit_count;
    int  full_count;
    int  too_long_count;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_out_word predict_match(t_in_word w);
        t_out_word r;
        t_entry    e;
        t_entry    hit;
        int        th;
        int        pos;
        th = w.thread % THREADS;
        e.key    = {w.sender, w.datatype, w.tag};
        e.handle = w.handle;
        e.length = w.length;
        r = '0;
        pos = -1;
        if (w.operation == OP_POST) begin
            for (int i = 0; i < unexpected_q[th].size(); i++)
                if (pos < 0 && unexpected_q[th][i].key == e.key) pos = i;
            if (pos >= 0) begin
                hit = unexpected_q[th][pos];
                unexpected_q[th].delete(pos);
                r.match_handle = hit.handle;
                if (hit.length > w.length) begin
                    r.status = ST_TOO_LONG;
                    r.match_length = w.length;
                end else begin
                    r.status = ST_MATCHED;
                    r.match_length = hit.length;
                end
            end else if (posted_q[th].size() < QUEUE_DEPTH) begin
                posted_q[th].push_back(e);
                r.status = ST_POSTED;
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            for (int i = 0; i < posted_q[th].size(); i++)
                if (pos < 0 && posted_q[th][i].key == e.key) pos = i;
            if (pos >= 0) begin
                hit = posted_q[th][pos];
                posted_q[th].delete(pos);
                r.match_handle = hit.handle;
                if (w.length > hit.length) begin
                    r.status = ST_TOO_LONG;
                    r.match_length = hit.length;
                end else begin
                    r.status = ST_MATCHED;
                    r.match_length = w.length;
                end
            end else if (unexpected_q[th].size() < QUEUE_DEPTH) begin
                unexpected_q[th].push_back(e);
                r.status = ST_UNEXPECTED;
            end else begin
                r.status = ST_FULL;
            end
        end
        return r;
    endfunction

    // Start stays high on return so the next word can follow at once
    task automatic send_word(t_in_word w);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_words.push_back(predict_match(w));
        words_sent++;
    endtask

    function automatic t_in_word make_word(logic op, int th, int key_sel);
        t_in_word w;
        w.operation = op;
        w.thread    = th[1:0];
        // narrow key pool so posts and arrivals meet often
        w.sender    = (key_sel < 0) ? 16'($urandom) : 16'(key_sel % 3);
        w.datatype  = (key_sel < 0) ? 8'($urandom) : 8'((key_sel / 3) % 2);
        w.tag       = (key_sel < 0) ? 16'($urandom) : 16'(16'hFFF0 + key_sel % 4);
        w.handle    = 16'($urandom);
        w.length    = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($urandom_range(60, 70));
        return w;
    endfunction

    // Check each strobed word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                exp_w = expected_words.pop_front();
                words_checked++;
                if (exp_w.status != o_result.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_w.status, o_result.status);
                    mismatch_count++;
                end
                if (exp_w.match_handle != o_result.match_handle) begin
                    $display("%0t: match_handle expected %h actual %h",
                             $time, exp_w.match_handle, o_result.match_handle);
                    mismatch_count++;
                end
                if (exp_w.match_length != o_result.match_length) begin
                    $display("%0t: match_length expected %h actual %h",
                             $time, exp_w.match_length, o_result.match_length);
                    mismatch_count++;
                end
                if (exp_w.status == ST_FULL) full_count++;
                if (exp_w.status == ST_TOO_LONG) too_long_count++;
                if (exp_w.status inside {ST_MATCHED, ST_TOO_LONG}) hit_count++;
            end
        end
    end

    // Watchdog: count cycles with no word accepted and no result strobed
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_extremes();
        t_in_word w;
        // all-ones and all-zero fields, both operations, every thread
        for (int th = 0; th < THREADS; th++) begin
            w = '1;
            w.operation = OP_POST;
            w.thread = th[1:0];
            send_word(w);
            w.operation = OP_ARRIVE;
            w.handle = 16'h0000;
            w.length = 16'h0000;
            send_word(w);
        end
        w = '0;
        w.operation = OP_ARRIVE;
        send_word(w);
        w.operation = OP_POST;
        w.handle = 16'hA5A5;
        w.length = 16'hFFFF;
        send_word(w);
    endtask

    task automatic test_too_long();
        t_in_word w;
        // arrival longer than the posted maximum, then post shorter than the message
        w = make_word(OP_POST, 1, 5);
        w.length = 16'd10;
        send_word(w);
        w.operation = OP_ARRIVE;
        w.length = 16'd11;
        send_word(w);
        w.length = 16'hFFFF;
        send_word(w);
        w.operation = OP_POST;
        w.length = 16'd0;
        send_word(w);
    endtask

    task automatic test_queue_full();
        t_in_word w;
        // fill one posted queue past its depth, then drain it in order
        for (int i = 0; i <= QUEUE_DEPTH; i++) begin
            w = make_word(OP_POST, 2, 7);
            send_word(w);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w = make_word(OP_ARRIVE, 2, 7);
            send_word(w);
        end
    endtask

    task automatic test_random(int count);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                w = make_word($urandom_range(0, 1), $urandom_range(0, 3), -1);
            else
                w = make_word($urandom_range(0, 1), $urandom_range(0, 3),
                              $urandom_range(0, 23));
            send_word(w);
        end
    endtask

    task automatic test_burst_fill(int count);
        t_in_word w;
        // lopsided stream to drive queues to full
        for (int i = 0; i < count; i++) begin
            w = make_word(($urandom_range(0, 4) == 0) ? OP_POST : OP_ARRIVE,
                          $urandom_range(0, 3), $urandom_range(0, 23));
            send_word(w);
        end
    endtask

    initial begin
        mismatch_count = 0;
        words_sent     = 0;
        words_checked  = 0;
        idle_cycles    = 0;
        hit_count      = 0;
        full_count     = 0;
        too_long_count = 0;
        gaps_on        = 1'b1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_word         = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_too_long();
        test_queue_full();
        test_random(450);
        test_burst_fill(150);
        gaps_on = 1'b0;
        test_random(100);
        start <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("Sent %0d words, checked %0d results: %0d hits, %0d too long, %0d drops",
                 words_sent, words_checked, hit_count, too_long_count, full_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> sim.f
src/putm_pkg.sv
src/posted_unexpected_tag_matcher_core.sv
verif/posted_unexpected_tag_matcher_core_test.sv
